/* rtl/core/fifo_with_remove_by_value_core_defines.svh */
// Assertion macros shared by the core RTL.
`ifndef FIFO_WITH_REMOVE_BY_VALUE_CORE_DEFINES_SVH
`define FIFO_WITH_REMOVE_BY_VALUE_CORE_DEFINES_SVH

// Check a property every clock edge, quiet while reset is asserted.
`define FWRV_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition in one cycle leads to another in the next cycle.
`define FWRV_ASSERT_NEXT(lbl, cond, conseq, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (conseq)) \
		else $error(msg);

`endif

/* rtl/core/fwrv_pkg.sv */
`timescale 1ns / 1ps

package fwrv_pkg;

	localparam int DATA_W = 32;
	localparam int CAP_W = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	typedef enum logic [1:0] {
		OP_PUSH   = 2'd0,
		OP_POP    = 2'd1,
		OP_DELETE = 2'd2,
		OP_NOP    = 2'd3
	} op_e;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_e;

	typedef struct packed {
		op_e                       op;
		logic signed [DATA_W-1:0] data_in;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] data_out;
		status_e                   status;
	} rsp_t;

	// Broadcast from the control to every cell of the row.
	typedef struct packed {
		logic              cmp;
		logic [DATA_W-1:0] cmp_data;
		logic              push;
		logic              pop;
		logic              del;
		logic [DATA_W-1:0] wdata;
	} cell_ctrl_t;

endpackage

/* rtl/core/fwrv_cell.sv */
`timescale 1ns / 1ps

`include "fifo_with_remove_by_value_core_defines.svh"

module fwrv_cell
	import fwrv_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cell_ctrl_t        ctrl,
	input  logic              prev_valid,
	input  logic [DATA_W-1:0] next_value,
	input  logic              next_valid,
	input  logic              any_in,
	output logic [DATA_W-1:0] value,
	output logic              valid,
	output logic              any_out
);

	logic [DATA_W-1:0] value_q;
	logic              valid_q;
	logic              match_q;
	logic              shift;
	logic              load;

	// A match here or in any newer cell marks this cell as at or below the newest hit.
	assign any_out = match_q | any_in;
	// Shift from the newest hit upward; cells under a newer hit hold.
	assign shift   = ctrl.pop | (ctrl.del & ~any_in);
	// Push lands in the lowest empty cell.
	assign load    = ctrl.push & ~valid_q & prev_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
		end else begin
			if (shift) begin
				valid_q <= next_valid;
			end else if (load) begin
				valid_q <= 1'b1;
			end
			if (ctrl.cmp) begin
				match_q <= valid_q && (value_q == ctrl.cmp_data);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			value_q <= next_value;
		end else if (load) begin
			value_q <= ctrl.wdata;
		end
	end

	assign value = value_q;
	assign valid = valid_q;

	`FWRV_ASSERT(a_match_needs_valid, match_q && !valid_q |-> !ctrl.del, "match on empty cell")
	`FWRV_ASSERT(a_push_exclusive, !(ctrl.push && (ctrl.pop || ctrl.del)), "push with shift")
	`FWRV_ASSERT_NEXT(a_load_fills, load && !shift, valid_q, "push did not fill cell")

endmodule

/* rtl/core/fifo_with_remove_by_value_core.sv */
`timescale 1ns / 1ps

// Bounded FIFO of 32-bit values with pop of the oldest entry and delete of
// the newest entry equal to a given value, the rest keeping their order. The
// entries live in a row of DEPTH cells, oldest in cell 0; a pop or delete
// shifts the cells above the removed entry down one place. The beat that
// accepts a request latches a compare result in every cell; the apply step
// then resolves the newest match through the cell chain, updates the row and
// loads the response register. A new request is not taken until the last one
// is applied, and a held response holds the update and so the next request.
// capacity may be written at any time while idle; values above DEPTH limit
// the queue to DEPTH, and lowering it below the fill level keeps the entries
// but reports full on push. Every request gives exactly one response with a
// status.
`include "fifo_with_remove_by_value_core_defines.svh"

module fifo_with_remove_by_value_core
	import fwrv_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  req_t             req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output rsp_t             rsp,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CAP_W-1:0] cfg_data
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int LW = (CW > CAP_W) ? CW : CAP_W;

	logic [CAP_W-1:0]  cap_q;
	logic [CW-1:0]     count_q;
	logic              pend_q;
	op_e               op_s1;
	logic [DATA_W-1:0] data_s1;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic [DATA_W-1:0] val_w [DEPTH];
	logic [DEPTH-1:0]  vld_w;
	logic [DEPTH-1:0]  any_w;
	cell_ctrl_t        ctrl;

	logic              apply;
	logic              found;
	logic [LW-1:0]     cap_ext;
	logic [LW-1:0]     lim;
	logic              full;
	logic              empty;
	rsp_t              rsp_d;

	assign cfg_ready = 1'b1;
	assign req_ready = !pend_q;
	assign apply     = pend_q && (!rsp_valid_q || rsp_ready);
	assign found     = any_w[0];
	assign empty     = (count_q == '0);

	assign cap_ext = LW'(cap_q);
	assign lim     = (cap_ext > LW'(DEPTH)) ? LW'(DEPTH) : cap_ext;
	assign full    = (LW'(count_q) >= lim);

	always_comb begin
		ctrl          = '0;
		ctrl.cmp      = req_valid && req_ready;
		ctrl.cmp_data = req.data_in;
		ctrl.wdata    = data_s1;
		ctrl.push     = apply && (op_s1 == OP_PUSH) && !full;
		ctrl.pop      = apply && (op_s1 == OP_POP) && !empty;
		ctrl.del      = apply && (op_s1 == OP_DELETE) && found;
	end

	always_comb begin
		rsp_d        = '0;
		rsp_d.status = ST_OK;
		unique case (op_s1)
			OP_PUSH: begin
				if (full) begin
					rsp_d.status = ST_FULL;
				end
			end
			OP_POP: begin
				if (empty) begin
					rsp_d.status = ST_EMPTY;
				end else begin
					rsp_d.data_out = val_w[0];
				end
			end
			OP_DELETE: begin
				if (!found) begin
					rsp_d.status = ST_NOT_FOUND;
				end
			end
			OP_NOP: begin
				rsp_d.status = ST_OK;
			end
			default: begin
				rsp_d.status = ST_OK;
			end
		endcase
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic              prev_v;
		logic [DATA_W-1:0] next_d;
		logic              next_v;
		logic              any_i;

		if (i == 0) begin : g_first
			assign prev_v = 1'b1;
		end else begin : g_mid
			assign prev_v = vld_w[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign next_d = '0;
			assign next_v = 1'b0;
			assign any_i  = 1'b0;
		end else begin : g_below
			assign next_d = val_w[i+1];
			assign next_v = vld_w[i+1];
			assign any_i  = any_w[i+1];
		end

		fwrv_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.prev_valid (prev_v),
			.next_value (next_d),
			.next_valid (next_v),
			.any_in     (any_i),
			.value      (val_w[i]),
			.valid      (vld_w[i]),
			.any_out    (any_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CAP_RESET;
			count_q     <= '0;
			pend_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			if (ctrl.push) begin
				count_q <= count_q + CW'(1);
			end else if (ctrl.pop || (ctrl.del && found)) begin
				count_q <= count_q - CW'(1);
			end
			if (req_valid && req_ready) begin
				pend_q <= 1'b1;
			end else if (apply) begin
				pend_q <= 1'b0;
			end
			if (apply) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Hold the request payload until it is applied.
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			op_s1   <= req.op;
			data_s1 <= req.data_in;
		end
		if (apply) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`FWRV_ASSERT(a_count_matches_row, $countones(vld_w) == int'(count_q), "count out of step")
	`FWRV_ASSERT(a_count_bound, int'(count_q) <= DEPTH, "count above depth")
	`FWRV_ASSERT(a_error_zero_data, rsp_valid && (rsp.status != ST_OK) |-> (rsp.data_out == '0), "error beat carries data")
	`FWRV_ASSERT_NEXT(a_accept_pends, req_valid && req_ready, pend_q, "request not held")

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
	import fwrv_pkg::*;

	localparam int DEPTH = 16;

	typedef enum bit {
		ROW_REQ,
		ROW_CFG
	} row_kind_e;

	typedef struct {
		row_kind_e   kind;
		op_e         op;
		logic [31:0] data;
		bit          typed;
		logic [31:0] exp_data;
		status_e     exp_st;
	} dir_row_t;

	logic             clk;
	logic             arst_n = 1'b0;
	logic             req_valid = 1'b0;
	logic             req_ready;
	req_t             req = '{op: OP_NOP, data_in: '0};
	logic             rsp_valid;
	logic             rsp_ready = 1'b0;
	rsp_t             rsp;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CAP_W-1:0] cfg_data = '0;

	// Typed-in expectation that travels with the request beat.
	bit   fixed_exp = 1'b0;
	rsp_t fixed_rsp = '{data_out: '0, status: ST_OK};

	logic [31:0] shadow_fifo[$];
	logic [CAP_W-1:0] shadow_cap = CAP_RESET;
	rsp_t pending_rsp[$];
	int accepted_items = 0;
	int mismatches = 0;
	int op_seen[4] = '{0, 0, 0, 0};
	int status_seen[4] = '{0, 0, 0, 0};
	int cap_writes = 0;
	logic [31:0] value_pool[8];

	dir_row_t dir_rows[0:26] = '{
		'{ROW_REQ, OP_POP,    32'h0000_0000, 1'b1, 32'h0000_0000, ST_EMPTY},
		'{ROW_REQ, OP_DELETE, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_NOT_FOUND},
		'{ROW_REQ, OP_NOP,    32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_OK},
		'{ROW_REQ, OP_PUSH,   32'h8000_0000, 1'b1, 32'h0000_0000, ST_OK},
		'{ROW_REQ, OP_PUSH,   32'h7FFF_FFFF, 1'b0, 32'h0000_0000, ST_OK},
		'{ROW_REQ, OP_PUSH,   32'hFFFF_FFFF, 1'b0, 32'h0000_0000, ST_OK},
		'{ROW_REQ, OP_PUSH,   32'h8000_0000, 1'b0, 32'h0000_0000, ST_OK},
		// newest of the two equal entries goes
		'{ROW_REQ, OP_DELETE, 32'h8000_0000, 1'b1, 32'h0000_0000, ST_OK},
		'{ROW_REQ, OP_DELETE, 32'h1234_5678, 1'b1, 32'h0000_0000, ST_NOT_FOUND},
		'{ROW_REQ, OP_POP,    32'h0000_0000, 1'b1, 32'h8000_0000, ST_OK},
		'{ROW_REQ, OP_POP,    32'h0000_0000, 1'b1, 32'h7FFF_FFFF, ST_OK},
		'{ROW_REQ, OP_POP,    32'h0000_0000, 1'b1, 32'hFFFF_FFFF, ST_OK},
		'{ROW_REQ, OP_POP,    32'h0000_0000, 1'b1, 32'h0000_0000, ST_EMPTY},
		'{ROW_CFG, OP_NOP,    32'd0,         1'b0, 32'h0000_0000, ST_OK},
		'{ROW_REQ, OP_PUSH,   32'h0000_0001, 1'b1, 32'h0000_0000, ST_FULL},
		'{ROW_CFG, OP_NOP,    32'd16,        1'b0, 32'h0000_0000, ST_OK},
		'{ROW_REQ, OP_PUSH,   32'hA5A5_A5A5, 1'b0, 32'h0000_0000, ST_OK},
		'{ROW_REQ, OP_PUSH,   32'h5A5A_5A5A, 1'b0, 32'h0000_0000, ST_OK},
		'{ROW_REQ, OP_PUSH,   32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK},
		// shrink below the fill level: entries stay, pushes bounce
		'{ROW_CFG, OP_NOP,    32'd1,         1'b0, 32'h0000_0000, ST_OK},
		'{ROW_REQ, OP_PUSH,   32'h0000_0001, 1'b1, 32'h0000_0000, ST_FULL},
		'{ROW_REQ, OP_POP,    32'h0000_0000, 1'b1, 32'hA5A5_A5A5, ST_OK},
		'{ROW_REQ, OP_PUSH,   32'h0000_0002, 1'b1, 32'h0000_0000, ST_FULL},
		'{ROW_REQ, OP_DELETE, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK},
		'{ROW_REQ, OP_POP,    32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK},
		'{ROW_REQ, OP_PUSH,   32'h0000_0003, 1'b0, 32'h0000_0000, ST_OK},
		'{ROW_REQ, OP_PUSH,   32'h0000_0004, 1'b1, 32'h0000_0000, ST_FULL}
	};

	fifo_with_remove_by_value_core #(
		.DEPTH(DEPTH)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// Apply one request to the shadow queue and return the response it gives.
	function automatic rsp_t apply_shadow(req_t r);
		rsp_t res;
		int limit;
		int hit;
		int i;
		res.data_out = '0;
		res.status = ST_OK;
		limit = (shadow_cap > DEPTH) ? DEPTH : int'(shadow_cap);
		hit = -1;
		case (r.op)
		OP_PUSH: begin
			if (shadow_fifo.size() >= limit)
				res.status = ST_FULL;
			else
				shadow_fifo.push_back(r.data_in);
		end
		OP_POP: begin
			if (shadow_fifo.size() == 0)
				res.status = ST_EMPTY;
			else
				res.data_out = shadow_fifo.pop_front();
		end
		OP_DELETE: begin
			for (i = shadow_fifo.size() - 1; i >= 0; i--)
				if (hit < 0 && shadow_fifo[i] == r.data_in)
					hit = i;
			if (hit < 0)
				res.status = ST_NOT_FOUND;
			else
				shadow_fifo.delete(hit);
		end
		default: ;
		endcase
		return res;
	endfunction

	always @(posedge clk) begin : monitor
		rsp_t pred;
		rsp_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				shadow_cap = cfg_data;
			if (req_valid && req_ready) begin
				pred = apply_shadow(req);
				want = fixed_exp ? fixed_rsp : pred;
				op_seen[req.op]++;
				status_seen[want.status]++;
				pending_rsp.push_back(want);
				accepted_items++;
			end
			if (rsp_valid && rsp_ready) begin
				if (pending_rsp.size() == 0) begin
					$error("response beat with nothing outstanding: data_out %h status %s",
						rsp.data_out, rsp.status.name());
					mismatches++;
				end else begin
					want = pending_rsp.pop_front();
					if (rsp.data_out !== want.data_out) begin
						$error("data_out: expected %h, got %h", want.data_out, rsp.data_out);
						mismatches++;
					end
					if (rsp.status !== want.status) begin
						$error("status: expected %s, got %s",
							want.status.name(), rsp.status.name());
						mismatches++;
					end
				end
			end
		end
	end

	// Response side: random stalls, one long hold-off, and a calm window.
	initial begin
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (!hold_done && accepted_items >= 420) begin
				hold_done = 1'b1;
				hold_left = 90;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else if (accepted_items >= 600 && accepted_items < 760)
				rsp_ready <= 1'b1;
			else
				rsp_ready <= ($urandom_range(99) >= 12);
		end
	end

	task automatic send_req(op_e code, logic [31:0] value, bit typed, rsp_t exp_r,
			bit may_idle);
		if (may_idle && $urandom_range(99) < 12) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= '{op: code, data_in: value};
		fixed_exp <= typed;
		fixed_rsp <= exp_r;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
	endtask

	// Drop valid and hold until every outstanding response has come back.
	task automatic wait_idle();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_rsp.size() != 0) @(posedge clk);
	endtask

	task automatic write_capacity(logic [CAP_W-1:0] value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		cap_writes++;
	endtask

	initial begin
		int r;
		int ph;
		int k;
		int sent;
		int roll;
		bit draining;
		op_e code;
		logic [31:0] value;
		rsp_t exp_r;
		logic [CAP_W-1:0] phase_caps[9];

		phase_caps = '{5'd16, 5'd31, 5'd2, 5'd0, 5'd17, 5'd1, 5'd0, 5'd5, 5'd16};
		phase_caps[6] = CAP_W'($urandom_range(31));
		value_pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			$urandom, $urandom, $urandom, $urandom};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (r = 0; r < $size(dir_rows); r++) begin
			if (dir_rows[r].kind == ROW_CFG)
				write_capacity(dir_rows[r].data[CAP_W-1:0]);
			else begin
				exp_r = '{data_out: dir_rows[r].exp_data, status: dir_rows[r].exp_st};
				send_req(dir_rows[r].op, dir_rows[r].data, dir_rows[r].typed, exp_r, 1'b1);
			end
		end

		sent = 24;
		for (ph = 0; ph < 9; ph++) begin
			write_capacity(phase_caps[ph]);
			for (k = 0; k < 100; k++) begin
				if (sent == 274)
					wait_idle();
				// alternate fill and drain stretches so the queue swings end to end
				draining = ((k / 40) % 2) == 1;
				roll = $urandom_range(99);
				if (roll < (draining ? 25 : 55))
					code = OP_PUSH;
				else if (roll < (draining ? 60 : 75))
					code = OP_POP;
				else if (roll < 95)
					code = OP_DELETE;
				else
					code = OP_NOP;
				if (code == OP_PUSH && $urandom_range(1) == 0)
					value = value_pool[$urandom_range(7)];
				else if (code == OP_DELETE && $urandom_range(9) < 8)
					value = value_pool[$urandom_range(7)];
				else
					value = $urandom;
				send_req(code, value, 1'b0, '{data_out: '0, status: ST_OK},
					!(sent >= 600 && sent < 760));
				sent++;
			end
		end

		wait_idle();
		repeat (20) @(posedge clk);

		$display("Covered %0d requests: %0d push, %0d pop, %0d delete, %0d no-op, across %0d capacity writes.",
			accepted_items, op_seen[OP_PUSH], op_seen[OP_POP], op_seen[OP_DELETE],
			op_seen[OP_NOP], cap_writes);
		$display("Responses seen: %0d ok, %0d full, %0d empty, %0d not found.",
			status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
			status_seen[ST_NOT_FOUND]);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
